>>> rtl/alm_pkg.sv
`default_nettype none

package alm_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_IDX_COEF     = 3'd0;
  localparam logic [2:0] CFG_IDX_OVERRIDE = 3'd1;
  localparam logic [2:0] CFG_IDX_LEVEL0   = 3'd2;

  localparam int LEVEL_COUNT = 6;
  localparam int SEG_COUNT   = 5;

  localparam logic [16:0] COEF_RESET     = 17'd6554;
  localparam logic [8:0]  OVERRIDE_RESET = 9'd256;
  localparam logic [16:0] COEF_ONE       = 17'd65536;
  localparam logic [9:0]  AVG_TOP        = 10'd1023;

  // Reciprocals are scaled by 2^RECIP_SHIFT; every dividend stays below that.
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

  // Segment k runs from breakpoint k to breakpoint k+1.
  localparam logic [9:0] SEG_X1 [SEG_COUNT] = '{10'd0, 10'd59, 10'd67, 10'd120, 10'd300};
  localparam logic [9:0] SEG_DX [SEG_COUNT] = '{10'd59, 10'd8, 10'd53, 10'd180, 10'd723};
  localparam logic [16:0] SEG_RECIP [SEG_COUNT] = '{
    17'(RECIP_ONE / 59), 17'(RECIP_ONE / 8), 17'(RECIP_ONE / 53),
    17'(RECIP_ONE / 180), 17'(RECIP_ONE / 723)
  };

  typedef logic [LEVEL_COUNT-1:0][8:0] level_vec_t;

  localparam level_vec_t LEVEL_RESET = {9'd15, 9'd15, 9'd32, 9'd64, 9'd96, 9'd160};

  typedef struct packed {
    logic [16:0] coef;
    logic [8:0]  override_level;
    level_vec_t  level;
  } cfg_t;

  typedef struct packed {
    logic       override;
    logic [9:0] sample;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/alm_front.sv
`default_nettype none

module alm_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [9:0]            light_sample,
  input  wire  [8:0]            override_level,
  input  alm_pkg::queue_status_t q_status,
  output logic                  q_push,
  output alm_pkg::queue_entry_t q_entry
);
  import alm_pkg::*;

  logic         held_valid;
  queue_entry_t held;

  // The held request moves into the queue whenever the queue has room.
  assign q_push   = held_valid && !q_status.full;
  assign in_stall = held_valid && q_status.full;
  assign q_entry  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= (in_valid && !in_stall) || (held_valid && !q_push);
    end
  end

  // A level below 256 forces the output and bypasses the average.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held.sample   <= light_sample;
      held.override <= !override_level[8];
    end
  end

endmodule

`default_nettype wire

>>> rtl/alm_fifo.sv
`default_nettype none

module alm_fifo (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  alm_pkg::queue_entry_t  wr_entry,
  input  wire                    pop,
  output alm_pkg::queue_entry_t  rd_entry,
  output alm_pkg::queue_status_t status
);
  import alm_pkg::*;

  queue_entry_t slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign rd_entry     = slot[rd_ptr];
  assign status.full  = count[1];
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/alm_back.sv
`default_nettype none

module alm_back (
  input  wire                    clk,
  input  wire                    rst,
  input  alm_pkg::cfg_t          cfg,
  input  alm_pkg::queue_entry_t  q_entry,
  input  alm_pkg::queue_status_t q_status,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [8:0]             brightness,
  output logic [9:0]             smoothed_light
);
  import alm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMA   = 3'd1;
  localparam logic [2:0] S_PROD  = 3'd2;
  localparam logic [2:0] S_RECIP = 3'd3;
  localparam logic [2:0] S_BACK  = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]          state;
  logic [9:0]          avg;
  logic                seeded;
  logic signed [37:0]  prod;
  logic [2:0]          seg;
  logic [9:0]          off;
  logic [8:0]          dy;
  logic [8:0]          y1;
  logic                down;
  logic [18:0]         n;
  logic [8:0]          q_est;
  logic [8:0]          res_bright;

  logic signed [19:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic [9:0]          base;
  logic signed [10:0]  diff;
  logic [16:0]         coef_sat;
  logic signed [37:0]  acc;
  logic [9:0]          new_avg;
  logic [2:0]          seg_sel;
  logic [8:0]          y2_sel;
  logic [18:0]         n_val;
  logic [19:0]         rem;
  logic [9:0]          q_fix;
  logic                out_free;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && !q_status.empty;

  // The first sample seeds the average; the update then leaves it unchanged.
  assign base     = seeded ? avg : q_entry.sample;
  assign diff     = $signed({1'b0, q_entry.sample}) - $signed({1'b0, base});
  assign coef_sat = cfg.coef[16] ? COEF_ONE : cfg.coef;

  // avg + c*(sample - avg) with rounding, kept at 16 fraction bits.
  assign acc     = $signed({12'd0, avg, 16'd0}) + prod + 38'sd32768;
  assign new_avg = acc[25:16];

  always_comb begin
    if (new_avg < SEG_X1[1]) begin
      seg_sel = 3'd0;
    end else if (new_avg < SEG_X1[2]) begin
      seg_sel = 3'd1;
    end else if (new_avg < SEG_X1[3]) begin
      seg_sel = 3'd2;
    end else if (new_avg < SEG_X1[4]) begin
      seg_sel = 3'd3;
    end else begin
      seg_sel = 3'd4;
    end
  end

  assign y2_sel = cfg.level[3'(seg_sel + 3'd1)];

  // A falling segment rounds the step up, so bias the dividend by dx - 1.
  assign n_val = prod[18:0] + (down ? 19'(SEG_DX[seg] - 10'd1) : 19'd0);

  // The reciprocal estimate is low by at most one.
  assign rem   = {1'b0, n} - prod[19:0];
  assign q_fix = {1'b0, q_est} + ((rem >= {10'd0, SEG_DX[seg]}) ? 10'd1 : 10'd0);

  // One shared multiplier; its product is registered every cycle.
  always_comb begin
    case (state)
      S_IDLE: begin
        mul_a = {{9{diff[10]}}, diff};
        mul_b = {1'b0, coef_sat};
      end
      S_PROD: begin
        mul_a = {10'd0, off};
        mul_b = {9'd0, dy};
      end
      S_RECIP: begin
        mul_a = {1'b0, n_val};
        mul_b = {1'b0, SEG_RECIP[seg]};
      end
      S_BACK: begin
        mul_a = {11'd0, prod[27:19]};
        mul_b = {8'd0, SEG_DX[seg]};
      end
      default: begin
        mul_a = 20'sd0;
        mul_b = 18'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      avg       <= 10'd0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_entry.override) begin
              state <= S_OUT;
            end else begin
              avg    <= base;
              seeded <= 1'b1;
              state  <= S_EMA;
            end
          end
        end
        S_EMA: begin
          avg <= new_avg;
          if (new_avg == AVG_TOP) begin
            state <= S_OUT;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          state <= S_RECIP;
        end
        S_RECIP: begin
          state <= S_BACK;
        end
        S_BACK: begin
          state <= S_FIX;
        end
        S_FIX: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_bright <= cfg.override_level;
      end
      S_EMA: begin
        res_bright <= cfg.level[LEVEL_COUNT-1];
        seg        <= seg_sel;
        off        <= new_avg - SEG_X1[seg_sel];
        y1         <= cfg.level[seg_sel];
        down       <= y2_sel < cfg.level[seg_sel];
        dy         <= (y2_sel < cfg.level[seg_sel]) ? cfg.level[seg_sel] - y2_sel
                                                    : y2_sel - cfg.level[seg_sel];
      end
      S_RECIP: begin
        n <= n_val;
      end
      S_BACK: begin
        q_est <= prod[27:19];
      end
      S_FIX: begin
        res_bright <= down ? y1 - q_fix[8:0] : y1 + q_fix[8:0];
      end
      S_OUT: begin
        if (out_free) begin
          brightness     <= res_bright;
          smoothed_light <= avg;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ambient_light_brightness_mapper_top.sv
// Ambient light brightness mapper.
// Input channel: in_valid / in_stall with one 10-bit light_sample per request.
// Output channel: out_valid / out_stall with brightness (9 bits) and
// smoothed_light (10 bits); every input request yields exactly one result.
// Configuration: cfg_valid / cfg_ready write port, cfg_index selects the
// coefficient (0), the override level (1) or a table level (2 to 7).
// Writes are taken in every cycle and belong in periods when no request is
// in flight.
// On an idle block an accepted request passes the front register and the queue
// before the back end takes it. The back end runs one request at a time
// through a single shared multiplier, in the four multiply steps of the
// moving average and the interpolation divide; the interpolation is skipped when
// the average sits at full scale, and under override the result goes straight out.
// A front register and a two-entry queue keep the input taking requests while
// the back end works or the receiver stalls; in_stall rises only when both
// are full. A stalled result holds on the outputs until it is taken.
// Synchronous reset restores all register defaults, clears the average and
// its seeded flag, and empties the queue and output.
`default_nettype none

module ambient_light_brightness_mapper_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [9:0]  light_sample,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [8:0]  brightness,
  output logic [9:0]  smoothed_light,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [16:0] cfg_data
);
  import alm_pkg::*;

  cfg_t          cfg;
  queue_entry_t  push_entry;
  queue_entry_t  pop_entry;
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef           <= COEF_RESET;
      cfg.override_level <= OVERRIDE_RESET;
      cfg.level          <= LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_COEF: begin
          cfg.coef <= cfg_data;
        end
        CFG_IDX_OVERRIDE: begin
          cfg.override_level <= cfg_data[8:0];
        end
        default: begin
          // Every remaining index names one of the six table levels.
          cfg.level[3'(cfg_index - CFG_IDX_LEVEL0)] <= cfg_data[8:0];
        end
      endcase
    end
  end

  // Front end: takes requests and tags the ones that the override answers.
  alm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .light_sample   (light_sample),
    .override_level (cfg.override_level),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_entry        (push_entry)
  );

  alm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (push_entry),
    .pop      (q_pop),
    .rd_entry (pop_entry),
    .status   (q_status)
  );

  // Back end: moving average, segment lookup and interpolation.
  alm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_entry        (pop_entry),
    .q_status       (q_status),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .brightness     (brightness),
    .smoothed_light (smoothed_light)
  );

endmodule

`default_nettype wire

>>> rtl/alm_checker.sv
`default_nettype none

module alm_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [8:0] brightness,
  input wire [9:0] smoothed_light
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(brightness) && $stable(smoothed_light))
    else $error("stalled result changed or dropped");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // Reset empties the front register and queue, so the input is open.
  assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind ambient_light_brightness_mapper_top alm_checker u_alm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .brightness     (brightness),
  .smoothed_light (smoothed_light)
);

`default_nettype wire
